FILE: rtl/pcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the programmer's calculator core
// Key codes, operator codes, register indexes and controller commands.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int unsigned WORD_BITS = 64;

  localparam logic [2:0] ACT_DIGIT     = 3'd0;
  localparam logic [2:0] ACT_CLEAR_ALL = 3'd1;
  localparam logic [2:0] ACT_CLEAR_ENT = 3'd2;
  localparam logic [2:0] ACT_BACKSPACE = 3'd3;
  localparam logic [2:0] ACT_OPERATOR  = 3'd4;
  localparam logic [2:0] ACT_BIT_FLIP  = 3'd5;

  localparam logic [3:0] OP_ROL    = 4'd0;
  localparam logic [3:0] OP_ROR    = 4'd1;
  localparam logic [3:0] OP_NOT    = 4'd2;
  localparam logic [3:0] OP_NEG    = 4'd3;
  localparam logic [3:0] OP_EQUALS = 4'd4;
  localparam logic [3:0] OP_MOD    = 4'd5;
  localparam logic [3:0] OP_OR     = 4'd6;
  localparam logic [3:0] OP_XOR    = 4'd7;
  localparam logic [3:0] OP_AND    = 4'd8;
  localparam logic [3:0] OP_LSH    = 4'd9;
  localparam logic [3:0] OP_RSH    = 4'd10;
  localparam logic [3:0] OP_DIV    = 4'd11;
  localparam logic [3:0] OP_MUL    = 4'd12;
  localparam logic [3:0] OP_SUB    = 4'd13;
  localparam logic [3:0] OP_ADD    = 4'd14;
  localparam logic [3:0] OP_NONE   = 4'd15;

  localparam logic REG_PRECISION = 1'b0;
  localparam logic REG_BASE      = 1'b1;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] digit;
    logic [3:0] operator_code;
    logic [5:0] bit_index;
  } key_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // latch the key and decode it
    logic div_start;   // start the divider and multiplier on the prepared operands
    logic commit;      // write the new state and result
    logic cfg_we;
  } pcc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
  } pcc_sts_t;

endpackage

FILE: rtl/pcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_if: valid/ready channel
// Carries one item of payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface pcc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_ctrl: controller of the calculator core
// Sequences key capture, optional division and result commit.
// ----------------------------------------------------------------------------
module pcc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_busy,
  input  pcc_pkg::pcc_sts_t sts,
  output pcc_pkg::pcc_cmd_t cmd
);
  import pcc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE) && !out_busy;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

FILE: rtl/pcc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_divider: signed restoring divider
// One quotient bit per cycle; quotient rounds toward zero, remainder takes
// the sign of the dividend.
// ----------------------------------------------------------------------------
module pcc_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);
  import pcc_pkg::*;

  logic        busy;
  logic [6:0]  count;
  logic [63:0] q;
  logic [63:0] r;
  logic [63:0] d;
  logic        neg_q;
  logic        neg_r;
  logic [64:0] trial;

  assign trial = {r, q[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == 7'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend[63] ? 64'(0 - dividend) : dividend;
      d     <= divisor[63] ? 64'(0 - divisor) : divisor;
      r     <= '0;
      count <= '0;
      neg_q <= dividend[63] ^ divisor[63];
      neg_r <= dividend[63];
    end else if (busy) begin
      count <= count + 7'd1;
      if (!trial[64]) begin
        r <= trial[63:0];
        q <= {q[62:0], 1'b1};
      end else begin
        r <= {r[62:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
    end
  end

  assign quotient  = neg_q ? 64'(0 - q) : q;
  assign remainder = neg_r ? 64'(0 - r) : r;
endmodule

FILE: rtl/pcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_datapath: state registers and arithmetic of the calculator core
// Holds the operands, pending operator and flags and forms each result.
// ----------------------------------------------------------------------------
module pcc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pcc_pkg::pcc_cmd_t cmd,
  output pcc_pkg::pcc_sts_t sts,
  input  pcc_pkg::key_t     key_in,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data,
  output logic [63:0]       result_value,
  output logic              result_rejected,
  output logic              result_div_zero
);
  import pcc_pkg::*;

  logic [1:0]  precision;
  logic [1:0]  numeral_base;
  logic [63:0] current_value;
  logic [63:0] previous_value;
  logic [3:0]  pending_operator;
  logic        awaiting_operand;
  logic        clear_on_digit;
  key_t        key;

  logic [4:0]  base;
  logic [6:0]  width;
  logic [63:0] mask;
  logic        run;       // a binary operation runs on this key
  logic        backsp;
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic        div_done;
  logic [63:0] div_q;
  logic [63:0] div_r;
  logic [63:0] mul_p;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] lo;
  logic [63:0] cur_next;
  logic [63:0] prev_next;
  logic        rej;
  logic        dz;

  function automatic logic [63:0] trunc(input logic [63:0] v, input logic [1:0] p);
    logic [63:0] r;
    r = v;
    unique case (p)
      2'd0: r = {{56{v[7]}}, v[7:0]};
      2'd1: r = {{48{v[15]}}, v[15:0]};
      2'd2: r = {{32{v[31]}}, v[31:0]};
      2'd3: r = v;
      default: r = v;
    endcase
    return r;
  endfunction

  always_comb begin
    unique case (numeral_base)
      2'd0: base = 5'd2;
      2'd1: base = 5'd8;
      2'd2: base = 5'd10;
      2'd3: base = 5'd16;
      default: base = 5'd10;
    endcase
    width = 7'(8) << precision;
    mask  = (width == 7'd64) ? '1 : ((64'd1 << width) - 64'd1);
  end

  assign run = (key.action == ACT_OPERATOR) && (key.operator_code >= OP_EQUALS)
               && (key.operator_code == OP_EQUALS || !awaiting_operand);
  assign backsp = (key.action == ACT_BACKSPACE) && !clear_on_digit;
  assign sts.need_div = backsp ||
      (run && (((pending_operator == OP_DIV || pending_operator == OP_MOD)
                && current_value != '0) || pending_operator == OP_MUL));
  assign sts.div_done = div_done;

  always_comb begin
    if (backsp) begin
      div_a = current_value;
      div_b = {59'd0, base};
    end else begin
      div_a = previous_value;
      div_b = current_value;
    end
  end

  pcc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Shift-and-add product, one multiplier bit per cycle alongside the divider.
  // Once all 64 bits are consumed further cycles leave the product unchanged.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      mul_p <= '0;
      mul_a <= previous_value;
      mul_b <= current_value;
    end else begin
      if (mul_b[0]) mul_p <= mul_p + mul_a;
      mul_a <= {mul_a[62:0], 1'b0};
      mul_b <= {1'b0, mul_b[63:1]};
    end
  end

  always_comb begin
    cur_next  = current_value;
    prev_next = previous_value;
    rej       = 1'b0;
    dz        = 1'b0;
    lo        = current_value & mask;
    unique case (key.action)
      ACT_DIGIT: begin
        if ({1'b0, key.digit} >= base) begin
          rej = 1'b1;
        end else if (clear_on_digit) begin
          prev_next = current_value;
          cur_next  = {60'd0, key.digit};
        end else begin
          cur_next = 64'(current_value * base) + {60'd0, key.digit};
        end
      end
      ACT_CLEAR_ALL: begin
        prev_next = '0;
        cur_next  = '0;
      end
      ACT_CLEAR_ENT: cur_next = '0;
      ACT_BACKSPACE: if (backsp) cur_next = div_q;
      ACT_OPERATOR: begin
        unique case (key.operator_code)
          OP_ROL: cur_next = ((lo << 1) | (lo >> (width - 7'd1))) & mask;
          OP_ROR: cur_next = ((lo >> 1) | ((lo & 64'd1) << (width - 7'd1))) & mask;
          OP_NOT: cur_next = ~current_value;
          OP_NEG: cur_next = 64'(0 - current_value);
          default: begin
            if (run) begin
              prev_next = current_value;
              unique case (pending_operator)
                OP_MOD: if (current_value == '0) dz = 1'b1; else cur_next = div_r;
                OP_DIV: if (current_value == '0) dz = 1'b1; else cur_next = div_q;
                OP_OR:  cur_next = previous_value | current_value;
                OP_XOR: cur_next = previous_value ^ current_value;
                OP_AND: cur_next = previous_value & current_value;
                OP_LSH: cur_next = (current_value >= 64'd64) ? '0 :
                                   previous_value << current_value[5:0];
                OP_RSH: cur_next = (current_value >= 64'd64) ?
                                   {64{previous_value[63]}} :
                                   64'($signed(previous_value) >>> current_value[5:0]);
                OP_MUL: cur_next = mul_p;
                OP_SUB: cur_next = previous_value - current_value;
                OP_ADD: cur_next = previous_value + current_value;
                default: cur_next = current_value;
              endcase
            end
          end
        endcase
      end
      ACT_BIT_FLIP: cur_next = current_value ^ (64'd1 << key.bit_index);
      default: cur_next = current_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      precision        <= 2'd3;
      numeral_base     <= 2'd2;
      current_value    <= '0;
      previous_value   <= '0;
      pending_operator <= OP_NONE;
      awaiting_operand <= 1'b0;
      clear_on_digit   <= 1'b0;
    end else if (cmd.cfg_we) begin
      if (cfg_index == REG_PRECISION) begin
        precision     <= cfg_data;
        current_value <= trunc(current_value, cfg_data);
      end else begin
        numeral_base <= cfg_data;
      end
    end else if (cmd.commit) begin
      current_value   <= trunc(cur_next, precision);
      previous_value  <= prev_next;
      result_value    <= trunc(cur_next, precision);
      result_rejected <= rej;
      result_div_zero <= dz;
      if (key.action == ACT_DIGIT && !rej) begin
        clear_on_digit   <= 1'b0;
        awaiting_operand <= 1'b0;
      end
      if (key.action == ACT_CLEAR_ALL) pending_operator <= OP_NONE;
      if (key.action == ACT_OPERATOR) begin
        clear_on_digit <= 1'b1;
        if (key.operator_code >= OP_EQUALS) awaiting_operand <= 1'b1;
        if (key.operator_code > OP_EQUALS) pending_operator <= key.operator_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) key <= key_in;
  end
endmodule

FILE: rtl/programmer_calculator_core.sv
`timescale 1ns / 1ps
// A key is captured, decoded and committed; a division, mod, multiply or
// backspace first waits for the divider and multiplier to finish.
// Throughput: one item at a time; the next is taken after the result leaves
// the output register. Reset (rst, synchronous) restores precision 64 bits,
// decimal base, zero values and no pending operator.
// ----------------------------------------------------------------------------
// programmer_calculator_core: keypad-driven 64-bit programmer's calculator
// Top level joining the controller, datapath and output register.
// ----------------------------------------------------------------------------
module programmer_calculator_core (
  input logic clk,
  input logic rst,
  pcc_if.sink   keys,
  pcc_if.sink   cfg,
  pcc_if.source result
);
  import pcc_pkg::*;

  pcc_cmd_t    cmd;
  pcc_cmd_t    cmd_c;
  pcc_sts_t    sts;
  logic        out_valid;
  logic        commit_q;
  logic [63:0] value;
  logic        rej;
  logic        dz;
  logic        idle;

  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (keys.valid),
    .in_ready (keys.ready),
    .out_busy (out_valid || commit_q),
    .sts      (sts),
    .cmd      (cmd_c)
  );

  assign idle     = keys.ready;
  assign cfg.ready = idle;
  always_comb begin
    cmd        = cmd_c;
    cmd.cfg_we = cfg.valid && idle;
  end

  pcc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .key_in          (keys.data),
    .cfg_index       (cfg.data.index),
    .cfg_data        (cfg.data.value),
    .result_value    (value),
    .result_rejected (rej),
    .result_div_zero (dz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      commit_q  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      commit_q <= cmd.commit;
      if (commit_q)                        out_valid <= 1'b1;
      else if (result.ready && out_valid)  out_valid <= 1'b0;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = {value, rej, dz};
endmodule
